// File: design/fpr_pkg.sv
// Shared constants and types for the framed packet receiver.
// No dependencies; used by framed_packet_receiver_unit.
package fpr_pkg;

    localparam int STATUS_BYTES_DEF = 6;
    localparam int STATUS_BYTES_MAX = 8;
    localparam int STAT_FIELDS      = 6;

    localparam logic [7:0] HEADER_BYTE = 8'd170;
    localparam logic [7:0] NIB_LO      = 8'h0f;
    localparam logic [7:0] NIB_HI      = 8'hf0;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;
    localparam int RES_W     = 76;

    // Link status codes
    typedef enum logic [2:0] {
        ST_OFFLINE = 3'd0,
        ST_OK      = 3'd1,
        ST_HEADER  = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_CORRUPT = 3'd4
    } link_status_t;

    // Result kind on m_tuser
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Input kind on s_tuser
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam logic [7:0] SB_RESET [STATUS_BYTES_MAX] =
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd80, 8'd100, 8'd0, 8'd0};

endpackage

// File: design/framed_packet_receiver_unit.sv
// Framed packet receiver: header, ID, status bytes, length, payload, footer.
// Results are registered into the output register, or into the skid register while it is held.
// Throughput: one input beat per cycle unless the skid holds a result; a two-entry
// output (register + skid) keeps s_tready high while one result waits on m_tready.
// Reset: synchronous active-low aresetn; waits for a header, link offline.
// Depends on fpr_pkg.
module framed_packet_receiver_unit #(
    parameter int STATUS_BYTES = fpr_pkg::STATUS_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [7:0] rx_byte, [11:8] sent_id, [15:12] zero
    input  logic [fpr_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] payload_byte, [10:8] status, [18:11] stat_a, [26:19] stat_b,
    // [34:27] stat_c, [42:35] stat_d, [50:43] stat_e, [58:51] stat_f,
    // [66:59] accept_len, [67] send_acked, [75:68] rx_id, [79:76] zero
    output logic [fpr_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] kind
    output logic                         m_tuser
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_STATUS,
        PH_LEN,
        PH_PAYLOAD,
        PH_FOOTER
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [7:0]            byte_count_reg, byte_count_next;
    logic [7:0]            frame_len_reg, frame_len_next;
    logic [7:0]            frame_id_reg, frame_id_next;
    logic [7:0]            running_sum_reg, running_sum_next;
    logic [7:0]            sb_reg [STATUS_BYTES];
    logic [7:0]            sb_next [STATUS_BYTES];
    fpr_pkg::link_status_t link_status_reg, link_status_next;
    logic [7:0]            last_id_reg, last_id_next;

    logic                          out_valid_reg, skid_valid_reg;
    logic [fpr_pkg::RES_W-1:0]     out_data_reg, skid_data_reg;
    logic                          out_user_reg, skid_user_reg;

    logic                      s_accept, out_take;
    logic                      timeout;
    logic [7:0]                rx_byte;
    logic [3:0]                sent_id;
    logic                      res_valid, res_user, res_summary;
    logic [7:0]                res_payload, res_acc;
    logic                      res_ack;
    logic [fpr_pkg::RES_W-1:0] res_data;
    logic [7:0]                stat_out [fpr_pkg::STAT_FIELDS];
    logic [7:0]                sum_plus;

    assign s_accept = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;
    assign timeout  = (s_tuser == fpr_pkg::REQ_TIMEOUT);
    assign rx_byte  = s_tdata[7:0];
    assign sent_id  = s_tdata[11:8];
    assign sum_plus = running_sum_reg + rx_byte;

    always_comb begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        frame_len_next   = frame_len_reg;
        frame_id_next    = frame_id_reg;
        running_sum_next = running_sum_reg;
        link_status_next = link_status_reg;
        last_id_next     = last_id_reg;
        for (int i = 0; i < STATUS_BYTES; i++) begin
            sb_next[i] = sb_reg[i];
        end
        res_valid   = 1'b0;
        res_summary = 1'b0;
        res_payload = 8'd0;
        res_acc     = 8'd0;
        res_ack     = 1'b0;

        if (phase_reg == PH_HEADER) begin
            if (!timeout && rx_byte == fpr_pkg::HEADER_BYTE) begin
                phase_next = PH_ID;
            end else begin
                if (link_status_reg != fpr_pkg::ST_OFFLINE) begin
                    link_status_next = fpr_pkg::ST_HEADER;
                end
                res_valid   = 1'b1;
                res_summary = 1'b1;
            end
        end else if (timeout) begin
            link_status_next = fpr_pkg::ST_TRUNC;
            phase_next       = PH_HEADER;
            res_valid        = 1'b1;
            res_summary      = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_ID: begin
                    frame_id_next    = rx_byte;
                    running_sum_next = rx_byte;
                    byte_count_next  = 8'd0;
                    phase_next       = PH_STATUS;
                end
                PH_STATUS: begin
                    for (int i = 0; i < STATUS_BYTES; i++) begin
                        if (byte_count_reg == 8'(i)) begin
                            sb_next[i] = rx_byte;
                        end
                    end
                    running_sum_next = sum_plus;
                    byte_count_next  = byte_count_reg + 8'd1;
                    if (byte_count_reg == 8'(STATUS_BYTES - 1)) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    frame_len_next  = rx_byte;
                    byte_count_next = 8'd0;
                    phase_next      = (rx_byte != 8'd0) ? PH_PAYLOAD : PH_FOOTER;
                end
                PH_PAYLOAD: begin
                    running_sum_next = sum_plus;
                    byte_count_next  = byte_count_reg + 8'd1;
                    if (byte_count_next >= frame_len_reg) begin
                        phase_next = PH_FOOTER;
                    end
                    res_valid   = 1'b1;
                    res_payload = rx_byte;
                end
                PH_FOOTER: begin
                    phase_next  = PH_HEADER;
                    res_valid   = 1'b1;
                    res_summary = 1'b1;
                    if (rx_byte != running_sum_reg) begin
                        link_status_next = fpr_pkg::ST_CORRUPT;
                    end else begin
                        link_status_next = fpr_pkg::ST_OK;
                        if (frame_id_reg != last_id_reg) begin
                            res_ack = ((frame_id_reg & fpr_pkg::NIB_LO) == {4'd0, sent_id});
                            if ((frame_id_reg & fpr_pkg::NIB_HI) !=
                                (last_id_reg & fpr_pkg::NIB_HI) &&
                                frame_len_reg != 8'd0) begin
                                res_acc = frame_len_reg;
                            end
                            last_id_next = frame_id_reg;
                        end
                    end
                end
                default: begin
                    // header phase handled above
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // Unused status slots read zero
    for (genvar g = 0; g < fpr_pkg::STAT_FIELDS; g++) begin : g_stat
        if (g < STATUS_BYTES) begin : g_used
            assign stat_out[g] = sb_next[g];
        end else begin : g_unused
            assign stat_out[g] = 8'd0;
        end
    end

    assign res_user = res_summary ? fpr_pkg::KIND_SUMMARY : fpr_pkg::KIND_PAYLOAD;

    always_comb begin
        if (res_summary) begin
            res_data = {last_id_next, res_ack, res_acc,
                        stat_out[5], stat_out[4], stat_out[3],
                        stat_out[2], stat_out[1], stat_out[0],
                        link_status_next, 8'd0};
        end else begin
            res_data = {68'd0, res_payload};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            byte_count_reg  <= 8'd0;
            frame_len_reg   <= 8'd0;
            frame_id_reg    <= 8'd0;
            running_sum_reg <= 8'd0;
            link_status_reg <= fpr_pkg::ST_OFFLINE;
            last_id_reg     <= 8'd0;
            for (int i = 0; i < STATUS_BYTES; i++) begin
                sb_reg[i] <= fpr_pkg::SB_RESET[i];
            end
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg       <= phase_next;
                byte_count_reg  <= byte_count_next;
                frame_len_reg   <= frame_len_next;
                frame_id_reg    <= frame_id_next;
                running_sum_reg <= running_sum_next;
                link_status_reg <= link_status_next;
                last_id_reg     <= last_id_next;
                for (int i = 0; i < STATUS_BYTES; i++) begin
                    sb_reg[i] <= sb_next[i];
                end
            end
            if (skid_valid_reg) begin
                // drain skid into the output register; no beat accepted here
                if (out_take) begin
                    out_data_reg   <= skid_data_reg;
                    out_user_reg   <= skid_user_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (s_accept && res_valid) begin
                if (!out_valid_reg || out_take) begin
                    out_data_reg  <= res_data;
                    out_user_reg  <= res_user;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_data_reg  <= res_data;
                    skid_user_reg  <= res_user;
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fpr_pkg::M_TDATA_W - fpr_pkg::RES_W){1'b0}}, out_data_reg};
    assign m_tuser  = out_user_reg;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_user_reg == fpr_pkg::KIND_PAYLOAD)
            |-> out_data_reg[fpr_pkg::RES_W-1:8] == '0)
        else $error("payload beat carries summary fields");

    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (frame_len_reg != 8'd0 &&
                                       byte_count_reg < frame_len_reg))
        else $error("payload phase with count past frame length");

    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STATUS) |-> (byte_count_reg < 8'(STATUS_BYTES)))
        else $error("status byte count out of range");

    a_link_stays_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (link_status_reg != fpr_pkg::ST_OFFLINE)
            |=> (link_status_reg != fpr_pkg::ST_OFFLINE))
        else $error("link fell back to offline");
`endif

endmodule
